[src/ps2mc_pkg.sv]
// shared types and constants for the ps2 mouse packet cursor block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ps2mc_pkg;

  localparam int CFG_BITS       = 12;
  localparam int CURSOR_BITS    = 12;
  localparam int COORD_BITS_DEF = 12;
  localparam int POS_X_RESET    = 512;
  localparam int POS_Y_RESET    = 256;
  localparam int CFG_W_RESET    = 1024;
  localparam int CFG_H_RESET    = 768;

  // config register indexes
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam int QDEPTH         = 2;
  localparam int QPTR_BITS      = $clog2(QDEPTH);

  // status byte bits
  localparam int ST_OUT_FULL    = 0;
  localparam int ST_AUX         = 5;

  // first packet byte bits
  localparam int BTN_SIGN_X     = 4;
  localparam int BTN_SIGN_Y     = 5;
  localparam int BTN_OVF_X      = 6;
  localparam int BTN_OVF_Y      = 7;

  typedef struct packed {
    logic [7:0] button_byte;
    logic [8:0] delta_x;
    logic [8:0] delta_y;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

[src/ps2_mouse_packet_cursor.sv]
// top level of the ps2 mouse packet cursor block: config registers, front end,
// packet queue and cursor back end; depends on ps2mc_pkg, ps2mc_front,
// ps2mc_queue, ps2mc_back
//
//   channel  dir  handshake          payload
//   in_      in   in_tvalid/tready   status byte, data byte
//   out_     out  out_tvalid/tready  cursor x, cursor y, buttons, dropped flag
//   cfg_     in   cfg_we             screen width (0), screen height (1)
//
// one item per cycle while the queue has room; after the third packet byte is taken
// the packet goes from the front end into the queue, then into the output register
// the two-entry queue sets in_tready; the output register stalls on out_tready
// synchronous active-low reset; the first item after reset is dropped
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_cursor
  import ps2mc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [15:0]         in_tdata,   // status_byte, data_byte
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [39:0]              out_tdata,  // cursor_x, cursor_y, button_flags, packet_dropped
  input  wire logic                cfg_we,
  input  wire logic                cfg_addr,
  input  wire logic [CFG_BITS-1:0] cfg_wdata
);

  logic [CFG_BITS-1:0]    width_r, height_r;
  logic                   item_take, push, pop;
  pkt_t                   push_pkt, head_pkt;
  qstat_t                 qstat;
  logic [CURSOR_BITS-1:0] cursor_x, cursor_y;
  logic [7:0]             button_flags;
  logic                   packet_dropped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_BITS'(CFG_W_RESET);
      height_r <= CFG_BITS'(CFG_H_RESET);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        CFG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default:           width_r  <= width_r;
      endcase
    end
  end

  assign in_tready = !qstat.full;
  assign item_take = in_tvalid && in_tready;

  ps2mc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_take   (item_take),
    .status_byte (in_tdata[7:0]),
    .data_byte   (in_tdata[15:8]),
    .push        (push),
    .push_pkt    (push_pkt)
  );

  ps2mc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .head_pkt (head_pkt),
    .qstat    (qstat)
  );

  ps2mc_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .screen_width   (width_r),
    .screen_height  (height_r),
    .head_pkt       (head_pkt),
    .qstat          (qstat),
    .pop            (pop),
    .res_valid      (out_tvalid),
    .res_ready      (out_tready),
    .cursor_x       (cursor_x),
    .cursor_y       (cursor_y),
    .button_flags   (button_flags),
    .packet_dropped (packet_dropped)
  );

  assign out_tdata = {7'd0, packet_dropped, button_flags, cursor_y, cursor_x};

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("packet pushed into a full queue");

  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32]) |-> (out_tdata[31] || out_tdata[30]))
    else $error("dropped flag without an overflow bit");

endmodule

`default_nettype wire

[src/ps2mc_front.sv]
// front end: drops the first event, filters on status and assembles 3-byte packets
// depends on ps2mc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ps2mc_front
  import ps2mc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_take,
  input  wire logic [7:0] status_byte,
  input  wire logic [7:0] data_byte,
  output logic            push,
  output pkt_t            push_pkt
);

  typedef enum logic [2:0] {
    PH_BUTTON = 3'b001,
    PH_DX     = 3'b010,
    PH_DY     = 3'b100
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       skip_first_r, skip_first_nxt;
  logic [7:0] button_r, button_nxt;
  logic [8:0] dx_r, dx_nxt;
  logic       ready_evt;

  assign ready_evt = item_take && !skip_first_r
                     && status_byte[ST_OUT_FULL] && status_byte[ST_AUX];

  always_comb begin
    phase_nxt      = phase_r;
    skip_first_nxt = skip_first_r;
    button_nxt     = button_r;
    dx_nxt         = dx_r;
    push           = 1'b0;
    if (item_take && skip_first_r) begin
      skip_first_nxt = 1'b0;
    end
    if (ready_evt) begin
      unique case (phase_r)
        PH_BUTTON: begin
          button_nxt = data_byte;
          phase_nxt  = PH_DX;
        end
        PH_DX: begin
          dx_nxt    = {button_r[BTN_SIGN_X], data_byte};
          phase_nxt = PH_DY;
        end
        PH_DY: begin
          push      = 1'b1;
          phase_nxt = PH_BUTTON;
        end
        default: begin
          phase_nxt = PH_BUTTON;
        end
      endcase
    end
  end

  assign push_pkt.button_byte = button_r;
  assign push_pkt.delta_x     = dx_r;
  assign push_pkt.delta_y     = {button_r[BTN_SIGN_Y], data_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_BUTTON;
      skip_first_r <= 1'b1;
      button_r     <= 8'd0;
      dx_r         <= 9'd0;
    end else begin
      phase_r      <= phase_nxt;
      skip_first_r <= skip_first_nxt;
      button_r     <= button_nxt;
      dx_r         <= dx_nxt;
    end
  end

endmodule

`default_nettype wire

[src/ps2mc_queue.sv]
// short packet queue between front end and cursor update
// depends on ps2mc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ps2mc_queue
  import ps2mc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire pkt_t push_pkt,
  input  wire logic pop,
  output pkt_t      head_pkt,
  output qstat_t    qstat
);

  localparam int CNT_BITS = $clog2(QDEPTH + 1);

  pkt_t                 mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == CNT_BITS'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign head_pkt    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/ps2mc_back.sv]
// back end: applies packets to the cursor, clamps it and holds the output register
// depends on ps2mc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ps2mc_back
  import ps2mc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [CFG_BITS-1:0] screen_width,
  input  wire logic [CFG_BITS-1:0] screen_height,
  input  wire pkt_t                head_pkt,
  input  wire qstat_t              qstat,
  output logic                     pop,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output logic [CURSOR_BITS-1:0]   cursor_x,
  output logic [CURSOR_BITS-1:0]   cursor_y,
  output logic [7:0]               button_flags,
  output logic                     packet_dropped
);

  localparam int SW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;
  localparam logic signed [SW-1:0] CMAX = SW'((1 << COORD_BITS) - 1);
  localparam logic [COORD_BITS-1:0] POS_X_RST = COORD_BITS'(POS_X_RESET);
  localparam logic [COORD_BITS-1:0] POS_Y_RST = COORD_BITS'(POS_Y_RESET);

  logic [COORD_BITS-1:0]  pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic                   dropped;
  logic signed [SW-1:0]   dx_ext, dy_ext, sum_x, sum_y;
  logic signed [SW-1:0]   lim_x, lim_y, hi_x, hi_y, clamp_x, clamp_y;
  logic [SW-1:0]          ox, oy;
  logic                   valid_r;
  logic [CURSOR_BITS-1:0] cx_r, cy_r;
  logic [7:0]             btn_r;
  logic                   drop_r;

  assign pop     = !qstat.empty && (!valid_r || res_ready);
  assign dropped = head_pkt.button_byte[BTN_OVF_X] || head_pkt.button_byte[BTN_OVF_Y];

  assign dx_ext = {{(SW - 9){head_pkt.delta_x[8]}}, head_pkt.delta_x};
  assign dy_ext = {{(SW - 9){head_pkt.delta_y[8]}}, head_pkt.delta_y};
  assign sum_x  = SW'(pos_x_r) + dx_ext;
  assign sum_y  = SW'(pos_y_r) - dy_ext;
  assign lim_x  = SW'(screen_width);
  assign lim_y  = SW'(screen_height);
  assign hi_x   = (lim_x > CMAX) ? CMAX : lim_x;
  assign hi_y   = (lim_y > CMAX) ? CMAX : lim_y;

  always_comb begin
    if (sum_x < 0) begin
      clamp_x = '0;
    end else if (sum_x > hi_x) begin
      clamp_x = hi_x;
    end else begin
      clamp_x = sum_x;
    end
    if (sum_y < 0) begin
      clamp_y = '0;
    end else if (sum_y > hi_y) begin
      clamp_y = hi_y;
    end else begin
      clamp_y = sum_y;
    end
  end

  assign pos_x_nxt = dropped ? pos_x_r : COORD_BITS'(clamp_x);
  assign pos_y_nxt = dropped ? pos_y_r : COORD_BITS'(clamp_y);
  assign ox        = SW'(pos_x_nxt);
  assign oy        = SW'(pos_y_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= POS_X_RST;
      pos_y_r <= POS_Y_RST;
      valid_r <= 1'b0;
    end else begin
      if (pop) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
        valid_r <= 1'b1;
      end else if (res_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cx_r   <= ox[CURSOR_BITS-1:0];
      cy_r   <= oy[CURSOR_BITS-1:0];
      btn_r  <= head_pkt.button_byte;
      drop_r <= dropped;
    end
  end

  assign res_valid      = valid_r;
  assign cursor_x       = cx_r;
  assign cursor_y       = cy_r;
  assign button_flags   = btn_r;
  assign packet_dropped = drop_r;

endmodule

`default_nettype wire
